>>> hdl/lpf_pkg.sv
// Package: shared widths, controller types and command/status structs for the factor block.
`timescale 1ns / 1ps

package lpf_pkg;

  localparam int WIDTH    = 32;
  localparam int FACTOR_W = WIDTH - 1;
  localparam int CNT_W    = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] FIRST_DIV = WIDTH'(3);
  localparam logic [WIDTH-1:0] DIV_STEP  = WIDTH'(2);
  localparam logic [WIDTH-1:0] EVEN_RES  = WIDTH'(2);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RES_MAG,
    RES_TWO,
    RES_DIV
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_step;
    logic     next_div;
    logic     set_res;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic m_lt2;
    logic m_even;
    logic div_last;
    logic q_lt_d;
    logic r_zero;
    logic out_free;
  } status_t;

endpackage

>>> hdl/lpf_if.sv
// Interfaces: valid/ready channels for the input value and the factor result.
`timescale 1ns / 1ps

interface lpf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpf_pkg::WIDTH-1:0]    n_value;

  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

interface lpf_out_if;
  logic                                valid;
  logic                                ready;
  logic [lpf_pkg::FACTOR_W-1:0]        factor;

  modport source (output valid, output factor, input ready);
  modport sink   (input valid, input factor, output ready);
endinterface

>>> hdl/least_prime_factor.sv
// Top level: least prime factor of a signed integer by trial division.
`timescale 1ns / 1ps

// This block takes one signed 32-bit value per transaction and returns the
// least prime factor of its magnitude as a 31-bit unsigned factor. Magnitudes
// 0 and 1 come back unchanged, even magnitudes give 2, and an odd magnitude is
// tried against 3, 5, 7, ... until a divisor divides it exactly or the quotient
// drops below the divisor, in which case the magnitude is prime and is returned.
// Items are processed one at a time. Zero, one and even values go from
// acceptance through classification straight to the result register. Each
// odd trial divisor costs a full run of the one-bit-per-cycle restoring
// divider followed by a check, so the search time grows with the divisor d
// at which the search ends; a 31-bit prime needs roughly 23170 trials. The
// divider is the one unit that sets the search time. The result sits in an
// output register, so a finished factor waiting on the downstream side does
// not hold off the next input transaction; the block only stalls in its final
// state if the previous result is still unclaimed.
// The block keeps no state between transactions.

module least_prime_factor (
  input  logic          clk,
  input  logic          rst_n,
  lpf_in_if.sink        in_if,
  lpf_out_if.source     out_if
);

  lpf_pkg::cmd_t    cmd;
  lpf_pkg::status_t st;

  // Sequencer: owns the input handshake and steps the datapath.
  lpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: magnitude, divisor, serial divider and the result register.
  lpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .n_value   (in_if.n_value),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .factor    (out_if.factor)
  );

  // An accepted transaction keeps the block busy for at least the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input accepted twice in consecutive cycles");

  // A result is written only into a free or draining output register.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result register overwritten before it was taken");

  // The output valid only rises after the controller handed off a result.
  a_valid_from_load : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a result hand-off");

  // Divider steps and divider restarts never coincide.
  a_div_cmd_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_step && cmd.div_start))
    else $error("divider step and restart issued together");

endmodule

>>> hdl/lpf_dp.sv
// Datapath: magnitude, trial divisor, bit-serial restoring divider and output register.
`timescale 1ns / 1ps

module lpf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpf_pkg::cmd_t                     cmd,
  output lpf_pkg::status_t                  st,
  input  logic signed [lpf_pkg::WIDTH-1:0]  n_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lpf_pkg::FACTOR_W-1:0]      factor
);

  logic [lpf_pkg::WIDTH-1:0] m_r, m_nxt;
  logic [lpf_pkg::WIDTH-1:0] d_r, d_nxt;
  logic [lpf_pkg::WIDTH-1:0] quo_r, quo_nxt;
  logic [lpf_pkg::WIDTH-1:0] rem_r, rem_nxt;
  logic [lpf_pkg::WIDTH-1:0] res_r, res_nxt;
  logic [lpf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lpf_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [lpf_pkg::WIDTH:0]   trial;
  logic                      fits;
  logic [lpf_pkg::WIDTH-1:0] mag;

  // Two's complement magnitude; the most negative value maps to 2^(WIDTH-1).
  assign mag = n_value[lpf_pkg::WIDTH-1] ? (~n_value + lpf_pkg::WIDTH'(1)) : n_value;

  // One restoring division step: bring down the next dividend bit.
  assign trial = {rem_r, quo_r[lpf_pkg::WIDTH-1]};
  assign fits  = (trial >= {1'b0, d_r});

  always_comb begin
    m_nxt         = m_r;
    d_nxt         = d_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    factor_nxt    = factor_r;
    out_valid_nxt = out_valid_r;

    if (cmd.load) begin
      m_nxt = mag;
      d_nxt = lpf_pkg::FIRST_DIV;
    end
    if (cmd.next_div) begin
      d_nxt = d_r + lpf_pkg::DIV_STEP;
    end
    if (cmd.div_start) begin
      quo_nxt = m_r;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem_nxt = lpf_pkg::WIDTH'(trial - {1'b0, d_r});
      end else begin
        rem_nxt = trial[lpf_pkg::WIDTH-1:0];
      end
      quo_nxt = {quo_r[lpf_pkg::WIDTH-2:0], fits};
      cnt_nxt = cnt_r + lpf_pkg::CNT_W'(1);
    end
    if (cmd.set_res) begin
      case (cmd.res_sel)
        lpf_pkg::RES_TWO: res_nxt = lpf_pkg::EVEN_RES;
        lpf_pkg::RES_DIV: res_nxt = d_r;
        default:          res_nxt = m_r;
      endcase
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      factor_nxt    = res_r[lpf_pkg::FACTOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    d_r      <= d_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    factor_r <= factor_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign st.m_lt2    = (m_r[lpf_pkg::WIDTH-1:1] == '0);
  assign st.m_even   = ~m_r[0];
  assign st.div_last = (cnt_r == lpf_pkg::LAST_BIT);
  assign st.q_lt_d   = (quo_r < d_r);
  assign st.r_zero   = (rem_r == '0);
  assign st.out_free = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign factor    = factor_r;

endmodule

>>> hdl/lpf_ctrl.sv
// Controller: sequences classification, trial divisions and the hand-off of each result.
`timescale 1ns / 1ps

module lpf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpf_pkg::status_t   st,
  output lpf_pkg::cmd_t      cmd
);

  lpf_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lpf_pkg::ST_CLASSIFY;
      end
      lpf_pkg::ST_CLASSIFY: begin
        if (st.m_lt2 || st.m_even) state_nxt = lpf_pkg::ST_FINISH;
        else                       state_nxt = lpf_pkg::ST_DIV;
      end
      lpf_pkg::ST_DIV: begin
        if (st.div_last) state_nxt = lpf_pkg::ST_CHECK;
      end
      lpf_pkg::ST_CHECK: begin
        if (st.q_lt_d || st.r_zero) state_nxt = lpf_pkg::ST_FINISH;
        else                        state_nxt = lpf_pkg::ST_DIV;
      end
      lpf_pkg::ST_FINISH: begin
        if (st.out_free) state_nxt = lpf_pkg::ST_IDLE;
      end
      default: state_nxt = lpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_sel = lpf_pkg::RES_MAG;
    in_ready = 1'b0;
    unique case (state_r)
      lpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lpf_pkg::ST_CLASSIFY: begin
        if (st.m_lt2) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = lpf_pkg::RES_MAG;
        end else if (st.m_even) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = lpf_pkg::RES_TWO;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      lpf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      lpf_pkg::ST_CHECK: begin
        if (st.q_lt_d) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = lpf_pkg::RES_MAG;
        end else if (st.r_zero) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = lpf_pkg::RES_DIV;
        end else begin
          // Moving on to the next divisor also restarts the divider.
          cmd.next_div  = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      lpf_pkg::ST_FINISH: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> tb/sv/tb_least_prime_factor.sv
// Testbench: random and corner-value checks of the least prime factor block against a local predictor.
`timescale 1ns / 1ps

// The driver feeds signed values from a queue of pending items over the input
// channel, and the monitor predicts the least prime factor of every value the
// block accepts. Each factor the block returns is compared with the oldest
// prediction. Both channel sides idle at random, with runs of back-to-back
// transactions in between, and once early in the run the receiver holds off
// for a long stretch so that the output register fills and the block stalls
// its input.
//
// Search time grows with the least factor: the later the search ends, the
// longer it runs, and a 31-bit prime is the slowest case. Only the two field
// extremes are that slow. The random values are built so that their search
// ends early, and a few of them reach divisors near 1000.

module tb_least_prime_factor;

  localparam int          RANDOM_ITEMS = 100;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned MAX_MAG      = 32'h7fff_ffff;

  // One prediction: the value that went in and the factor it must give.
  typedef struct packed {
    logic signed [lpf_pkg::WIDTH-1:0] n_value;
    logic [lpf_pkg::FACTOR_W-1:0]     factor;
  } factor_check_t;

  logic clk;
  logic rst_n;

  lpf_in_if  in_if ();
  lpf_out_if out_if ();

  least_prime_factor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic signed [lpf_pkg::WIDTH-1:0] pending_values [$];
  factor_check_t                    expected_factors [$];

  int   items_sent   = 0;
  int   factors_seen = 0;
  int   mismatches   = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  logic long_hold    = 1'b0;

  // Acceptance flags, sampled at the rising edge and used by the processes
  // that drive at the falling edge.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Least prime factor of the magnitude of a signed value. The most negative
  // value negates to 2^(WIDTH-1) at full width, which is even, so it gives 2.
  function automatic logic [lpf_pkg::FACTOR_W-1:0] least_factor_of(
    input logic signed [lpf_pkg::WIDTH-1:0] n);
    logic [lpf_pkg::WIDTH-1:0] mag;
    logic [lpf_pkg::WIDTH-1:0] d;
    mag = n;
    if (n[lpf_pkg::WIDTH-1]) begin
      mag = ~mag + 1'b1;
    end
    if (mag < 2) begin
      return lpf_pkg::FACTOR_W'(mag);
    end
    if (!mag[0]) begin
      return lpf_pkg::FACTOR_W'(2);
    end
    // Odd divisors are tried only while the quotient is not below the
    // divisor, so a square of a prime is still caught at its root.
    for (d = 3; mag / d >= d; d = d + 2) begin
      if (mag % d == 0) begin
        return lpf_pkg::FACTOR_W'(d);
      end
    end
    return lpf_pkg::FACTOR_W'(mag);
  endfunction

  // Driver: holds the current value until it is accepted, then idles for the
  // drawn gap before it offers the next one. Every fourth run of eight items
  // goes without gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.n_value <= '0;
      gap_left      <= 0;
    end else if (in_if.valid && !in_taken) begin
      in_if.valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_if.valid <= 1'b0;
      gap_left    <= gap_left - 1;
    end else if (pending_values.size() > 0) begin
      in_if.valid   <= 1'b1;
      in_if.n_value <= pending_values.pop_front();
      gap_left      <= ((items_sent % 32) >= 24) ? 0 : $urandom_range(0, 19);
      items_sent    <= items_sent + 1;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Long hold-off: once the second factor has come back, the receiver refuses
  // results for a fixed stretch while the driver keeps offering cheap values.
  // The block then fills its output register, finishes the next value and
  // stops accepting input until the hold ends.
  always @(negedge clk) begin
    if (!rst_n) begin
      long_hold <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && factors_seen >= 2) begin
      long_hold <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      long_hold <= 1'b0;
    end
  end

  // Receiver: after each accepted result, ready stays low for the drawn
  // number of cycles.
  always @(negedge clk) begin
    int wait_now;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (long_hold) begin
      out_if.ready <= 1'b0;
    end else if (out_taken) begin
      wait_now     = ((factors_seen % 32) >= 24) ? 0 : $urandom_range(0, 19);
      stall_left   <= wait_now;
      out_if.ready <= (wait_now == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: predicts each accepted input and checks each accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    factor_check_t want;
    in_taken  <= in_if.valid && in_if.ready;
    out_taken <= out_if.valid && out_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        want.n_value = in_if.n_value;
        want.factor  = least_factor_of(in_if.n_value);
        expected_factors = {expected_factors, want};
      end
      if (out_if.valid && out_if.ready) begin
        factors_seen++;
        if (expected_factors.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected factor %0d with no input outstanding", out_if.factor);
          end
          mismatches++;
        end else begin
          want = expected_factors.pop_front();
          if (out_if.factor !== want.factor) begin
            if (mismatches < 10) begin
              $display("factor mismatch for n_value %0d: expected %0d, got %0d",
                       want.n_value, want.factor, out_if.factor);
            end
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic signed [lpf_pkg::WIDTH-1:0] corner_values [0:19];
    logic signed [lpf_pkg::WIDTH-1:0] v;
    int unsigned                      mag;
    int unsigned                      p;
    int unsigned                      q;
    int unsigned                      k;
    int unsigned                      pick;

    rst_n = 1'b0;

    // Cheap values come first so the long hold-off finds the block busy with
    // fast work. Then zero and one passing through, signs, even values, three
    // as a prime whose search ends at its first divisor, squares and small composites,
    // the most negative value, and last the two slow field extremes.
    corner_values = '{0, 1, -1, 2, -2, 4, 6, 3, -3, 9, 15, -25, 35, 97, 63001,
                      2147483646, -2147483646, 32'sh8000_0000, 2147483647,
                      -2147483647};
    foreach (corner_values[i]) begin
      pending_values = {pending_values, corner_values[i]};
    end

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Any even value of either sign; this walks every bit but bit 0.
        v    = $urandom;
        v[0] = 1'b0;
      end else begin
        if (pick < 65) begin
          // A small odd prime times an odd cofactor, anywhere in range.
          do p = 2 * $urandom_range(1, 48) + 1; while (least_factor_of(p) != p);
          k   = 2 * $urandom_range(0, (MAX_MAG / p - 1) / 2) + 1;
          mag = p * k;
        end else if (pick < 80) begin
          // Product of two primes, the smaller one between 101 and 997, so
          // the search runs through hundreds of divisors.
          do p = 2 * $urandom_range(50, 498) + 1; while (least_factor_of(p) != p);
          do q = 2 * $urandom_range(p / 2, 2499) + 1; while (least_factor_of(q) != q);
          mag = p * q;
        end else if (pick < 90) begin
          // A prime below 2^16: the search runs out without a divisor.
          do mag = 2 * $urandom_range(1, 32767) + 1; while (least_factor_of(mag) != mag);
        end else begin
          mag = $urandom_range(0, 64);
        end
        v = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      end
      pending_values = {pending_values, v};
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_values.size() != 0 || in_if.valid || expected_factors.size() != 0) begin
      @(posedge clk);
    end
    // Wait out the drain period to catch any result the block should not send.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_least_prime_factor passed");
    end else begin
      $display("tb_least_prime_factor failed");
    end
    $finish;
  end

  // The two 31-bit primes take most of the run time, and this time limit
  // leaves ample room for them and for the rest of the run.
  initial begin
    #150_000_000;
    $display("tb_least_prime_factor failed");
    $finish;
  end

endmodule
